// File: design/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

  // Default sizing of the slot table and the time counter
  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths of the request and result items
  localparam int SLOT_W = 4;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;

  // Request modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One slot table entry
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  // Control from the sequencer to the pick unit
  typedef struct packed {
    logic start;
    logic cand_valid;
  } pick_ctl_t;

  // Status from the pick unit back to the sequencer
  typedef struct packed {
    logic found;
    logic act_any;
    logic act_multi;
  } pick_stat_t;

endpackage

`default_nettype wire

// File: design/pps_if.sv
// Request and result channel interfaces of the scheduler.
`default_nettype none

interface pps_req_if
  import pps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] burst_length;
  logic [PRIO_W-1:0] priority_level;

  modport source (
    output valid, mode, slot, arrival_time, burst_length, priority_level,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, arrival_time, burst_length, priority_level,
    output ready
  );
endinterface

interface pps_rsp_if
  import pps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              ran;
  logic [SLOT_W-1:0] running_slot;
  logic              switched;
  logic [TIME_W-1:0] tick_time;
  logic              completed;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] waiting_time;
  logic [TIME_W-1:0] turnaround_time;
  logic              all_done;
  logic              time_overflow;

  modport source (
    output valid, ran, running_slot, switched, tick_time, completed, finish_time,
           waiting_time, turnaround_time, all_done, time_overflow,
    input  ready
  );
  modport sink (
    input  valid, ran, running_slot, switched, tick_time, completed, finish_time,
           waiting_time, turnaround_time, all_done, time_overflow,
    output ready
  );
endinterface

`default_nettype wire

// File: design/pps_table.sv
// Slot table memory: one write port, one registered read port.
`default_nettype none

module pps_table
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  localparam int IDX_W = $clog2(MAX_TASKS)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire entry_t           wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output entry_t                rdata
);

  entry_t mem [MAX_TASKS];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/pps_pick.sv
// Pick unit: compares one slot per cycle against the best slot seen so far.
`default_nettype none

module pps_pick
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_TASKS),
  localparam int TW = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pick_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] cand_idx,
  input  wire logic             cand_present,
  input  wire entry_t           cand_entry,
  input  wire logic [TW-1:0]    now,
  output pick_stat_t            stat,
  output logic [IDX_W-1:0]      sel_idx,
  output entry_t                sel_entry
);

  logic active;
  logic eligible;
  logic better;

  // Qualify the candidate; strict less-than keeps the lowest index on ties
  assign active   = cand_present && (cand_entry.remaining != '0);
  assign eligible = active && (TW'(cand_entry.arrival) <= now);
  assign better   = !stat.found || (cand_entry.prio < sel_entry.prio);

  // Track the best eligible slot and count active slots up to two
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (ctl.start) begin
      stat <= '0;
    end else if (ctl.cand_valid) begin
      if (eligible && better) begin
        stat.found <= 1'b1;
      end
      stat.act_any   <= stat.act_any | active;
      stat.act_multi <= stat.act_multi | (stat.act_any & active);
    end
  end

  // Hold the winning entry
  always_ff @(posedge clk) begin
    if (ctl.cand_valid && eligible && better) begin
      sel_idx   <= cand_idx;
      sel_entry <= cand_entry;
    end
  end

endmodule

`default_nettype wire

// File: design/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler: sequencer, time and results.
//
// Requests arrive on req (valid/ready). A load request (mode 0) writes one
// slot's arrival, burst and priority in the cycle it is accepted and returns
// nothing; a load to slot MAX_TASKS or above is dropped. A tick request
// (mode 1) walks the slot table through the single read port of the table
// memory, one slot per cycle, while the pick unit keeps the best slot.
// The walk sets the rate: req.ready stays low from the acceptance of a tick
// until its result is registered. One result per tick leaves on rsp
// (valid/ready) from an output register; loads are taken while a result
// waits. If the result register is still full when the next tick ends,
// that tick holds in its last step until rsp.ready frees the register.
// Reset clears the present bits, the time counter and the last-run slot;
// table contents are not cleared and are only read for present slots.
// The time counter saturates at 2^TIME_BITS - 1 and reports time_overflow.
`default_nettype none

module preemptive_priority_scheduler_unit
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  pps_req_if.sink   req,
  pps_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int TW = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_WRAP
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     idx;
  logic [MAX_TASKS-1:0] present;
  logic [TIME_BITS-1:0] cur_time;
  logic [TIME_BITS-1:0] time_next;
  logic [IDX_W-1:0]     last_slot;
  logic                 last_valid;

  // Candidate pipeline alongside the registered table read
  logic                 cand_valid;
  logic [IDX_W-1:0]     cand_idx;
  logic                 cand_present;

  // Per-tick working registers
  logic [TW-1:0]        finish;
  logic [TW-1:0]        tat;
  logic                 done;
  logic                 sw;

  // Result register
  logic                 out_valid;
  logic                 out_ran;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_switched;
  logic [TIME_W-1:0]    out_tick_time;
  logic                 out_completed;
  logic [TIME_W-1:0]    out_finish;
  logic [TIME_W-1:0]    out_wait;
  logic [TIME_W-1:0]    out_tat;
  logic                 out_all_done;
  logic                 out_overflow;

  logic                 accept;
  logic                 tick_go;
  logic                 load_go;
  logic                 out_free;
  logic                 tbl_we;
  logic [IDX_W-1:0]     tbl_waddr;
  entry_t               tbl_wdata;
  entry_t               tbl_rdata;
  entry_t               load_entry;
  entry_t               wb_entry;
  pick_ctl_t            pick_ctl;
  pick_stat_t           pick_stat;
  logic [IDX_W-1:0]     sel_idx;
  entry_t               sel_entry;
  logic [TW-1:0]        now_ext;
  logic [TW-1:0]        arr_ext;
  logic [TW-1:0]        burst_ext;
  logic [TW-1:0]        wait_val;
  logic                 any_left;

  // Decode the request handshake
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign tick_go   = accept && (req.mode == MODE_TICK);
  assign load_go   = accept && (req.mode == MODE_LOAD) &&
                     (32'(req.slot) < 32'(MAX_TASKS));
  assign out_free  = !out_valid || rsp.ready;

  // Build table writes: loads from the request, write-back after a run
  always_comb begin
    load_entry.arrival   = req.arrival_time;
    load_entry.burst     = req.burst_length;
    load_entry.prio      = req.priority_level;
    load_entry.remaining = req.burst_length;
    wb_entry             = sel_entry;
    wb_entry.remaining   = sel_entry.remaining - TIME_W'(1);
  end

  assign tbl_we    = load_go || ((state == ST_CALC) && pick_stat.found);
  assign tbl_waddr = load_go ? IDX_W'(req.slot) : sel_idx;
  assign tbl_wdata = load_go ? load_entry : wb_entry;

  pps_table #(
    .MAX_TASKS (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (idx),
    .rdata (tbl_rdata)
  );

  assign pick_ctl.start      = tick_go;
  assign pick_ctl.cand_valid = cand_valid;
  assign now_ext             = TW'(cur_time);

  pps_pick #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .clk          (clk),
    .rst          (rst),
    .ctl          (pick_ctl),
    .cand_idx     (cand_idx),
    .cand_present (cand_present),
    .cand_entry   (tbl_rdata),
    .now          (now_ext),
    .stat         (pick_stat),
    .sel_idx      (sel_idx),
    .sel_entry    (sel_entry)
  );

  // Finish the time arithmetic of the winning slot
  assign arr_ext   = TW'(sel_entry.arrival);
  assign burst_ext = TW'(sel_entry.burst);
  assign wait_val  = (done && (tat > burst_ext)) ? (tat - burst_ext) : '0;
  assign any_left  = pick_stat.found ? (pick_stat.act_multi || !done) : pick_stat.act_any;
  assign time_next = (cur_time != TIME_MAX) ? (cur_time + TIME_BITS'(1)) : cur_time;

  // Sequence one tick and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      present    <= '0;
      cur_time   <= '0;
      last_slot  <= '0;
      last_valid <= 1'b0;
      cand_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cand_valid   <= (state == ST_SCAN);
      cand_idx     <= idx;
      cand_present <= present[idx];
      // Fill the result register at the end of a tick, drop it once taken
      if ((state == ST_WRAP) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (load_go) begin
            present[IDX_W'(req.slot)] <= 1'b1;
          end
          if (tick_go) begin
            idx    <= '0;
            finish <= (cur_time != TIME_MAX) ? TW'(cur_time + TIME_BITS'(1))
                                             : TW'(cur_time);
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          done <= pick_stat.found && (sel_entry.remaining == TIME_W'(1));
          tat  <= (finish > arr_ext) ? (finish - arr_ext) : '0;
          sw   <= pick_stat.found && (!last_valid || (last_slot != sel_idx));
          if (pick_stat.found) begin
            last_slot  <= sel_idx;
            last_valid <= 1'b1;
          end
          state <= ST_WRAP;
        end
        ST_WRAP: begin
          if (out_free) begin
            out_ran       <= pick_stat.found;
            out_slot      <= pick_stat.found ? SLOT_W'(sel_idx) : '0;
            out_switched  <= sw;
            out_tick_time <= TIME_W'(cur_time);
            out_completed <= done;
            out_finish    <= done ? TIME_W'(finish) : '0;
            out_wait      <= TIME_W'(wait_val);
            out_tat       <= done ? TIME_W'(tat) : '0;
            out_all_done  <= !any_left;
            out_overflow  <= (time_next == TIME_MAX);
            cur_time      <= time_next;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Drive the result channel
  assign rsp.valid           = out_valid;
  assign rsp.ran             = out_ran;
  assign rsp.running_slot    = out_slot;
  assign rsp.switched        = out_switched;
  assign rsp.tick_time       = out_tick_time;
  assign rsp.completed       = out_completed;
  assign rsp.finish_time     = out_finish;
  assign rsp.waiting_time    = out_wait;
  assign rsp.turnaround_time = out_tat;
  assign rsp.all_done        = out_all_done;
  assign rsp.time_overflow   = out_overflow;

  // A completed or switched result always comes with a slot that ran
  a_done_needs_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_completed || out_switched) |-> out_ran)
    else $error("completion or switch reported on an idle tick");

  // The chosen slot must be a loaded slot
  a_sel_present: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && pick_stat.found |-> present[sel_idx])
    else $error("picked slot is not present");

  // Saturated time stays saturated
  a_time_sticky: assert property (@(posedge clk) disable iff (rst)
    cur_time == TIME_MAX |=> cur_time == TIME_MAX)
    else $error("time counter left its maximum");

  // Time only moves when a tick result is issued
  a_time_steps: assert property (@(posedge clk) disable iff (rst)
    (state != ST_WRAP) |=> $stable(cur_time))
    else $error("time counter moved outside a tick");

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench of the preemptive priority scheduler: directed rows, random task sets, far arrivals.
module tb;
  import pps_pkg::*;

  localparam int                NSLOTS       = MAX_TASKS_DEF;
  localparam logic [TIME_W-1:0] TIME_TOP     = {TIME_W{1'b1}};
  localparam int                RAND_ITEMS   = 1325;
  localparam int                DRAIN_CYCLES = 40;
  localparam longint            CYCLE_LIMIT  = 5_000_000;
  localparam int                MAX_PRINTS   = 40;
  localparam int                HOLD_CYCLES  = 400;
  localparam int                HOLD_AT_TICK = 250;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } sched_req_t;

  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] running_slot;
    logic              switched;
    logic [TIME_W-1:0] tick_time;
    logic              completed;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              all_done;
    logic              time_overflow;
  } tick_rpt_t;

  typedef struct packed {
    sched_req_t rq;
    logic       typed;
    tick_rpt_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic calm = 1'b0;

  pps_req_if req_if ();
  pps_rsp_if rsp_if ();

  preemptive_priority_scheduler_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // Scheduler state as predicted from the accepted requests
  logic              slot_live [NSLOTS];
  logic [TIME_W-1:0] slot_arr  [NSLOTS];
  logic [TIME_W-1:0] slot_len  [NSLOTS];
  logic [PRIO_W-1:0] slot_prio [NSLOTS];
  logic [TIME_W-1:0] slot_left [NSLOTS];
  logic [TIME_W-1:0] sched_now;
  logic [SLOT_W-1:0] prev_slot;
  logic              prev_valid;

  tick_rpt_t pending_reports [$];
  dir_row_t  dir_rows [$];

  int n_errors = 0;
  int n_checked = 0;
  int n_loads = 0;
  int n_ticks = 0;
  int n_items = 0;
  int n_done = 0;
  int n_switch = 0;
  int n_idle = 0;
  int n_ovf = 0;

  // Apply one request to the predicted state; return 1 with the report for a tick
  function automatic logic sched_advance(input sched_req_t r, output tick_rpt_t t);
    logic              found;
    logic              left_any;
    int                i;
    int                sel;
    logic [PRIO_W-1:0] best;
    logic [TIME_W-1:0] fin;
    t = '0;
    if (r.mode == MODE_LOAD) begin
      slot_live[r.slot] = 1'b1;
      slot_arr[r.slot]  = r.arrival;
      slot_len[r.slot]  = r.burst;
      slot_prio[r.slot] = r.prio;
      slot_left[r.slot] = r.burst;
      return 1'b0;
    end
    found = 1'b0;
    sel   = 0;
    best  = '0;
    for (i = 0; i < NSLOTS; i++) begin
      if (slot_live[i] && slot_left[i] != '0 && slot_arr[i] <= sched_now &&
          (!found || slot_prio[i] < best)) begin
        found = 1'b1;
        best  = slot_prio[i];
        sel   = i;
      end
    end
    t.tick_time = sched_now;
    if (found) begin
      slot_left[sel] = slot_left[sel] - 1'b1;
      t.ran          = 1'b1;
      t.running_slot = SLOT_W'(sel);
      t.switched     = !prev_valid || prev_slot != SLOT_W'(sel);
      if (slot_left[sel] == '0) begin
        fin                = (sched_now != TIME_TOP) ? sched_now + 1'b1 : TIME_TOP;
        t.completed        = 1'b1;
        t.finish_time      = fin;
        t.turnaround_time  = (fin > slot_arr[sel]) ? fin - slot_arr[sel] : '0;
        t.waiting_time     = (t.turnaround_time > slot_len[sel]) ?
                             t.turnaround_time - slot_len[sel] : '0;
      end
      prev_slot  = SLOT_W'(sel);
      prev_valid = 1'b1;
    end
    left_any = 1'b0;
    for (i = 0; i < NSLOTS; i++) begin
      if (slot_live[i] && slot_left[i] != '0) left_any = 1'b1;
    end
    t.all_done = !left_any;
    if (sched_now != TIME_TOP) sched_now = sched_now + 1'b1;
    t.time_overflow = (sched_now == TIME_TOP);
    return 1'b1;
  endfunction

  // True while some unfinished task has arrived or arrives shortly
  function automatic logic work_near();
    int i;
    for (i = 0; i < NSLOTS; i++) begin
      if (slot_live[i] && slot_left[i] != '0 && slot_arr[i] <= sched_now + 8) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic sched_req_t mk_load(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b, input logic [PRIO_W-1:0] p);
    sched_req_t r;
    r.mode    = MODE_LOAD;
    r.slot    = s;
    r.arrival = a;
    r.burst   = b;
    r.prio    = p;
    return r;
  endfunction

  // Tick with random don't-care fields
  function automatic sched_req_t mk_tick();
    sched_req_t r;
    r      = mk_load(SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom), PRIO_W'($urandom));
    r.mode = MODE_TICK;
    return r;
  endfunction

  // Well-formed task: arrived already or arrives soon, mostly short burst
  function automatic sched_req_t rand_task();
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    int                pick;
    if ($urandom_range(0, 3) != 0) a = sched_now + TIME_W'($urandom_range(0, 6));
    else a = TIME_W'($urandom_range(0, sched_now));
    pick = $urandom_range(0, 99);
    if (pick < 85) b = TIME_W'($urandom_range(1, 6));
    else if (pick < 97) b = TIME_W'($urandom_range(7, 40));
    else b = TIME_W'($urandom_range(41, 120));
    return mk_load(SLOT_W'($urandom), a, b, PRIO_W'($urandom));
  endfunction

  function automatic tick_rpt_t mk_rpt(input logic ran, input logic [SLOT_W-1:0] s,
                                       input logic sw, input logic [TIME_W-1:0] tt,
                                       input logic cmp, input logic [TIME_W-1:0] fin,
                                       input logic [TIME_W-1:0] wt, input logic [TIME_W-1:0] tat,
                                       input logic ad);
    tick_rpt_t t;
    t.ran             = ran;
    t.running_slot    = s;
    t.switched        = sw;
    t.tick_time       = tt;
    t.completed       = cmp;
    t.finish_time     = fin;
    t.waiting_time    = wt;
    t.turnaround_time = tat;
    t.all_done        = ad;
    t.time_overflow   = 1'b0;
    return t;
  endfunction

  function automatic dir_row_t row(input sched_req_t r, input logic typed, input tick_rpt_t w);
    dir_row_t d;
    d.rq    = r;
    d.typed = typed;
    d.want  = w;
    return d;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input dir_row_t d);
    dir_rows = {dir_rows, d};
  endfunction

  // Queue one expected report behind the ones already waiting
  function automatic void add_report(input tick_rpt_t t);
    pending_reports = {pending_reports, t};
  endfunction

  task automatic note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string name, input longint unsigned got_v,
                           input longint unsigned want_v, input logic [TIME_W-1:0] tt);
    if (got_v != want_v)
      note_mismatch($sformatf("tick %0d %s: got %0d, want %0d", tt, name, got_v, want_v));
  endtask

  // Compare one accepted tick report with the oldest prediction
  task automatic check_report();
    tick_rpt_t got;
    tick_rpt_t want;
    got.ran             = rsp_if.ran;
    got.running_slot    = rsp_if.running_slot;
    got.switched        = rsp_if.switched;
    got.tick_time       = rsp_if.tick_time;
    got.completed       = rsp_if.completed;
    got.finish_time     = rsp_if.finish_time;
    got.waiting_time    = rsp_if.waiting_time;
    got.turnaround_time = rsp_if.turnaround_time;
    got.all_done        = rsp_if.all_done;
    got.time_overflow   = rsp_if.time_overflow;
    if (pending_reports.size() == 0) begin
      note_mismatch($sformatf("tick report with none pending, tick_time %0d", got.tick_time));
      return;
    end
    want = pending_reports.pop_front();
    cmp_field("ran", got.ran, want.ran, want.tick_time);
    cmp_field("running_slot", got.running_slot, want.running_slot, want.tick_time);
    cmp_field("switched", got.switched, want.switched, want.tick_time);
    cmp_field("tick_time", got.tick_time, want.tick_time, want.tick_time);
    cmp_field("completed", got.completed, want.completed, want.tick_time);
    cmp_field("finish_time", got.finish_time, want.finish_time, want.tick_time);
    cmp_field("waiting_time", got.waiting_time, want.waiting_time, want.tick_time);
    cmp_field("turnaround_time", got.turnaround_time, want.turnaround_time, want.tick_time);
    cmp_field("all_done", got.all_done, want.all_done, want.tick_time);
    cmp_field("time_overflow", got.time_overflow, want.time_overflow, want.tick_time);
    n_checked++;
    if (want.completed) n_done++;
    if (want.switched) n_switch++;
    if (!want.ran) n_idle++;
    if (want.time_overflow) n_ovf++;
  endtask

  // Offer one request, hold it until accepted, then idle for a random gap that may be zero
  task automatic send_request(input sched_req_t r, input logic typed, input tick_rpt_t want);
    tick_rpt_t pred;
    int        gap;
    int        pick;
    req_if.valid          <= 1'b1;
    req_if.mode           <= r.mode;
    req_if.slot           <= r.slot;
    req_if.arrival_time   <= r.arrival;
    req_if.burst_length   <= r.burst;
    req_if.priority_level <= r.prio;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (sched_advance(r, pred)) begin
      if (typed) add_report(want);
      else add_report(pred);
      n_ticks++;
    end else begin
      n_loads++;
    end
    n_items++;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 40);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: check accepted reports, stall at random, one long hold-off
  initial begin : rsp_side
    int   stall;
    int   hold_left;
    logic hold_used;
    int   pick;
    stall     = 0;
    hold_left = 0;
    hold_used = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) check_report();
      if (!hold_used && n_checked >= HOLD_AT_TICK) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          rsp_if.ready <= 1'b1;
        end else begin
          rsp_if.ready <= 1'b0;
          stall = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(8, 60);
        end
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at cycle limit with %0d reports pending", pending_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus: directed rows, random task sets, then tasks parked far in the future
  initial begin : stimulus
    int         k;
    int         s;
    int         n;
    int         ticks;
    int         ep;
    int         target;
    sched_req_t rq;
    rst                   <= 1'b1;
    req_if.valid          <= 1'b0;
    req_if.mode           <= MODE_LOAD;
    req_if.slot           <= '0;
    req_if.arrival_time   <= '0;
    req_if.burst_length   <= '0;
    req_if.priority_level <= '0;
    for (k = 0; k < NSLOTS; k++) slot_live[k] = 1'b0;
    sched_now  = '0;
    prev_slot  = '0;
    prev_valid = 1'b0;

    // Empty table, single short task, zero burst, tie, preemption, extremes, reload
    add_row(row(mk_tick(), 1'b1, mk_rpt(0, 0, 0, 0, 0, 0, 0, 0, 1)));
    add_row(row(mk_load(0, 0, 1, 255), 1'b0, '0));
    add_row(row(mk_tick(), 1'b1, mk_rpt(1, 0, 1, 1, 1, 2, 1, 2, 1)));
    add_row(row(mk_load(15, 0, 0, 0), 1'b0, '0));
    add_row(row(mk_tick(), 1'b1, mk_rpt(0, 0, 0, 2, 0, 0, 0, 0, 1)));
    add_row(row(mk_load(3, 0, 3, 100), 1'b0, '0));
    add_row(row(mk_load(5, 0, 2, 100), 1'b0, '0));
    add_row(row(mk_load(7, 5, 2, 0), 1'b0, '0));
    repeat (7) add_row(row(mk_tick(), 1'b0, '0));
    add_row(row(mk_load(10, TIME_TOP, TIME_TOP, 0), 1'b0, '0));
    add_row(row(mk_load(9, 0, TIME_TOP, 255), 1'b0, '0));
    add_row(row(mk_tick(), 1'b0, '0));
    add_row(row(mk_load(9, 0, 1, 128), 1'b0, '0));
    add_row(row(mk_tick(), 1'b0, '0));
    add_row(row(mk_load(12, 3, 2, 0), 1'b0, '0));
    repeat (2) add_row(row(mk_tick(), 1'b0, '0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

    // Random task sets run while work is near, with late arrivals and some noise
    target = n_items + RAND_ITEMS;
    ep     = 0;
    while (n_items < target) begin
      ep++;
      calm = (ep % 9 == 4);
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) send_request(rand_task(), 1'b0, '0);
        ticks = 0;
        while (work_near() && ticks < 40) begin
          if ($urandom_range(0, 99) < 8) send_request(rand_task(), 1'b0, '0);
          else send_request(mk_tick(), 1'b0, '0);
          ticks++;
        end
        repeat ($urandom_range(0, 2)) send_request(mk_tick(), 1'b0, '0);
      end else begin
        rq = mk_tick();
        if ($urandom_range(0, 1) != 0) begin
          rq       = mk_load(SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom_range(1, 65535)),
                             PRIO_W'($urandom));
        end
        send_request(rq, 1'b0, '0);
      end
    end

    // Clear every slot, park tasks at far arrival times, then run a few near ones
    calm = 1'b1;
    for (s = 0; s < NSLOTS; s++)
      send_request(mk_load(SLOT_W'(s), TIME_W'($urandom), '0, PRIO_W'($urandom)), 1'b0, '0);
    send_request(mk_load(1, TIME_TOP - 5, 10, 0), 1'b0, '0);
    send_request(mk_load(2, TIME_TOP, 3, 1), 1'b0, '0);
    send_request(mk_load(4, 40000, 2, 200), 1'b0, '0);
    send_request(mk_load(6, TIME_TOP - 15, 32, 5), 1'b0, '0);
    send_request(mk_load(11, 0, 2, 0), 1'b0, '0);
    send_request(mk_load(12, TIME_TOP, 1, 0), 1'b0, '0);
    repeat (6) send_request(mk_tick(), 1'b0, '0);
    req_if.valid <= 1'b0;

    // Drain outstanding reports and let the last request settle
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads and %0d ticks: %0d completions, %0d switches, %0d idle ticks.",
             n_loads, n_ticks, n_done, n_switch, n_idle);
    $display("Far arrivals left waiting at the end; %0d saturated, %0d checked, %0d errors.",
             n_ovf, n_checked, n_errors);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
design/pps_pkg.sv
design/pps_if.sv
design/pps_table.sv
design/pps_pick.sv
design/preemptive_priority_scheduler_unit.sv
verif/tb.sv
